// ===== rtl/dlag_pkg.sv =====
`default_nettype none

package dlag_pkg;

    // Default grid side; the top level hands its parameter down from here.
    localparam int GRID_SIDE_DEF = 8;

    // Fixed widths of the interface fields.
    localparam int POS_OUT_W = 3;
    localparam int COUNT_W   = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] TARGET_RESET = 7'd21;

    // Register index of target_count on the configuration port.
    localparam logic REG_TARGET = 1'b0;

    // Walk direction codes.
    localparam logic [1:0] DIR_XDEC = 2'd0;
    localparam logic [1:0] DIR_XINC = 2'd1;
    localparam logic [1:0] DIR_YDEC = 2'd2;
    localparam logic [1:0] DIR_YINC = 2'd3;

    // Action codes.
    localparam logic ACT_RESTART = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_PLACE = 4'b0010,
        PH_WALK  = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ST_SEEDED  = 3'd0,
        ST_REJECT  = 3'd1,
        ST_PLACED  = 3'd2,
        ST_MOVED   = 3'd3,
        ST_STUCK   = 3'd4,
        ST_IGNORED = 3'd5
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [POS_OUT_W-1:0]   pos_x;
        logic [POS_OUT_W-1:0]   pos_y;
        logic [COUNT_W-1:0]     particle_count;
        logic                   done_res;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/dlag_step.sv =====
`default_nettype none

// Next-state logic for one item: reads the bitmap and the walker, decides the
// outcome and produces the updated state and the result.
module dlag_step
    import dlag_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int CELLS     = GRID_SIDE * GRID_SIDE,
    parameter int POS_W     = ($clog2(GRID_SIDE) > POS_OUT_W) ? $clog2(GRID_SIDE) : POS_OUT_W
)
(
    input  wire logic [CELLS-1:0]     occ,
    input  wire logic [POS_W-1:0]     walker_x,
    input  wire logic [POS_W-1:0]     walker_y,
    input  wire phase_t               phase,
    input  wire logic [COUNT_W-1:0]   count,
    input  wire logic [COUNT_W-1:0]   target,
    input  wire logic                 action,
    input  wire logic [POS_OUT_W-1:0] rand_x,
    input  wire logic [POS_OUT_W-1:0] rand_y,
    input  wire logic [1:0]           rand_dir,
    output logic [CELLS-1:0]          occ_next,
    output logic [POS_W-1:0]          walker_x_next,
    output logic [POS_W-1:0]          walker_y_next,
    output phase_t                    phase_next,
    output logic [COUNT_W-1:0]        count_next,
    output result_t                   result
);

    localparam int IDX_W = $clog2(CELLS);
    localparam logic [POS_W-1:0] LAST = POS_W'(GRID_SIDE - 1);
    localparam logic [POS_W-1:0] HALF = POS_W'(GRID_SIDE / 2 - 1);

    function automatic logic [IDX_W-1:0] cell_idx(input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] y);
        cell_idx = IDX_W'(int'(y) * GRID_SIDE + int'(x));
    endfunction

    // Any of the four neighbors occupied; the position is inside the grid.
    function automatic logic has_nb(input logic [CELLS-1:0] map,
                                    input logic [POS_W-1:0] x,
                                    input logic [POS_W-1:0] y);
        has_nb = ((x != '0)   && map[cell_idx(x - 1'b1, y)]) ||
                 ((x != LAST) && map[cell_idx(x + 1'b1, y)]) ||
                 ((y != '0)   && map[cell_idx(x, y - 1'b1)]) ||
                 ((y != LAST) && map[cell_idx(x, y + 1'b1)]);
    endfunction

    logic               clear;
    logic               stick;
    logic               in_grid;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [POS_W-1:0]   rx_ext;
    logic [POS_W-1:0]   ry_ext;
    logic [CELLS-1:0]   occ_base;
    logic [COUNT_W-1:0] count_base;
    status_t            status;

    assign rx_ext  = POS_W'(rand_x);
    assign ry_ext  = POS_W'(rand_y);
    assign in_grid = (int'(rand_x) < GRID_SIDE) && (int'(rand_y) < GRID_SIDE);

    // Decide the outcome of the item.
    always_comb
    begin
        clear         = 1'b0;
        stick         = 1'b0;
        px            = '0;
        py            = '0;
        walker_x_next = walker_x;
        walker_y_next = walker_y;
        status        = ST_IGNORED;
        phase_next    = phase;
        if (action == ACT_RESTART)
        begin
            clear         = 1'b1;
            stick         = 1'b1;
            px            = HALF + POS_W'(rand_x[0]);
            py            = HALF + POS_W'(rand_y[0]);
            walker_x_next = px;
            walker_y_next = py;
            status        = ST_SEEDED;
        end
        else
        begin
            case (phase)
                PH_PLACE:
                begin
                    px = rx_ext;
                    py = ry_ext;
                    if (!in_grid || occ[cell_idx(rx_ext, ry_ext)])
                    begin
                        status = ST_REJECT;
                    end
                    else
                    begin
                        walker_x_next = rx_ext;
                        walker_y_next = ry_ext;
                        if (has_nb(occ, rx_ext, ry_ext))
                        begin
                            stick  = 1'b1;
                            status = ST_STUCK;
                        end
                        else
                        begin
                            phase_next = PH_WALK;
                            status     = ST_PLACED;
                        end
                    end
                end
                PH_WALK:
                begin
                    case (rand_dir)
                        DIR_XDEC:
                        begin
                            if (walker_x != '0)
                                walker_x_next = walker_x - 1'b1;
                        end
                        DIR_XINC:
                        begin
                            if (walker_x != LAST)
                                walker_x_next = walker_x + 1'b1;
                        end
                        DIR_YDEC:
                        begin
                            if (walker_y != '0)
                                walker_y_next = walker_y - 1'b1;
                        end
                        default:
                        begin
                            if (walker_y != LAST)
                                walker_y_next = walker_y + 1'b1;
                        end
                    endcase
                    px = walker_x_next;
                    py = walker_y_next;
                    if (has_nb(occ, walker_x_next, walker_y_next))
                    begin
                        stick  = 1'b1;
                        status = ST_STUCK;
                    end
                    else
                    begin
                        status = ST_MOVED;
                    end
                end
                default:
                begin
                    status = ST_IGNORED;
                end
            endcase
        end

        // Sticking sets the cell, bumps the count and re-evaluates the phase.
        occ_base   = clear ? '0 : occ;
        count_base = clear ? '0 : count;
        occ_next   = occ_base;
        count_next = count_base;
        if (stick)
        begin
            occ_next   = occ_base | (CELLS'(1) << cell_idx(px, py));
            count_next = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
            phase_next = (count_next >= target) ? PH_DONE : PH_PLACE;
        end
    end

    // Result fields; positions are reported in the low bits.
    always_comb
    begin
        result.status         = status;
        result.pos_x          = px[POS_OUT_W-1:0];
        result.pos_y          = py[POS_OUT_W-1:0];
        result.particle_count = count_next;
        result.done_res       = (phase_next == PH_DONE);
    end

endmodule

`default_nettype wire

// ===== rtl/dla_grid_aggregation_unit.sv =====
// Diffusion-limited aggregation engine on a GRID_SIDE x GRID_SIDE bitmap.
// Random draws arrive on the slave stream: s_tuser is the action (restart or
// draw), s_tdata carries rand_x, rand_y and rand_dir. Each accepted item gives
// exactly one result on the master stream: m_tuser is the status code, m_tdata
// carries the reported position, the particle count and the done flag.
// Every item is handled combinationally: the bitmap neighbor lookup and update
// sit between the input handshake and the output register, and one item can
// be taken every cycle unless the receiver stalls. The output register frees
// up in the same cycle it is drained, so a new item is taken while m_tready
// is high even if a result is still waiting; when the receiver stalls with a
// result held, s_tready drops until that result is transferred.
// The target particle count is set through the APB port at address 0 and
// should only be changed while the stream is idle.
// Reset clears the bitmap, walker, count and phase; the block is
// then idle and ignores draws until a restart item seeds the grid.
`default_nettype none

module dla_grid_aggregation_unit
    import dlag_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rand_x[2:0], rand_y[5:3], rand_dir[7:6]
    input  wire logic [0:0]  s_tuser,   // action[0]
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // pos_x[2:0], pos_y[5:3], particle_count[12:6],
                                        // done_res[13], zero[15:14]
    output logic [2:0]       m_tuser,   // status[2:0]
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int POS_W = ($clog2(GRID_SIDE) > POS_OUT_W) ? $clog2(GRID_SIDE) : POS_OUT_W;

    logic [CELLS-1:0]   occ_reg;
    logic [CELLS-1:0]   occ_next;
    logic [POS_W-1:0]   walker_x_reg;
    logic [POS_W-1:0]   walker_x_next;
    logic [POS_W-1:0]   walker_y_reg;
    logic [POS_W-1:0]   walker_y_next;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] target_reg;
    logic               m_tvalid_reg;
    result_t            result_reg;
    result_t            result_next;
    logic               in_xfer;
    logic               cfg_wr;

    // Handshakes.
    assign pready   = 1'b1;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_TARGET);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= TARGET_RESET;
        else if (cfg_wr)
            target_reg <= pwdata[COUNT_W-1:0];
    end

    assign prdata = (paddr[2] == REG_TARGET) ? 32'(target_reg) : '0;

    // Per-item decision logic.
    dlag_step #(
        .GRID_SIDE (GRID_SIDE),
        .CELLS     (CELLS),
        .POS_W     (POS_W)
    ) u_step (
        .occ           (occ_reg),
        .walker_x      (walker_x_reg),
        .walker_y      (walker_y_reg),
        .phase         (phase_reg),
        .count         (count_reg),
        .target        (target_reg),
        .action        (s_tuser[0]),
        .rand_x        (s_tdata[2:0]),
        .rand_y        (s_tdata[5:3]),
        .rand_dir      (s_tdata[7:6]),
        .occ_next      (occ_next),
        .walker_x_next (walker_x_next),
        .walker_y_next (walker_y_next),
        .phase_next    (phase_next),
        .count_next    (count_next),
        .result        (result_next)
    );

    // Grid and walker state, updated on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            walker_x_reg <= '0;
            walker_y_reg <= '0;
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
        end
        else if (in_xfer)
        begin
            occ_reg      <= occ_next;
            walker_x_reg <= walker_x_next;
            walker_y_reg <= walker_y_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (in_xfer)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            result_reg <= result_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = {2'b00, result_reg.done_res, result_reg.particle_count,
                       result_reg.pos_y, result_reg.pos_x};

    // Every accepted item leaves a result in the output register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> m_tvalid_reg)
        else $error("accepted item produced no result");

    // A restart always leaves the idle phase.
    a_restart_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (s_tuser[0] == ACT_RESTART)) |=> (phase_reg != PH_IDLE))
        else $error("restart left the block idle");

    // An unseeded grid is empty.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> ((occ_reg == '0) && (count_reg == '0)))
        else $error("idle phase with occupied cells or nonzero count");

    // The walker stays inside the grid while walking.
    a_walker_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WALK) |->
            ((int'(walker_x_reg) < GRID_SIDE) && (int'(walker_y_reg) < GRID_SIDE)))
        else $error("walker outside the grid");

endmodule

`default_nettype wire
